@@ hdl/be3_pkg.sv @@
package be3_pkg;

	// Pixel and register widths
	localparam int PIX_W        = 8;
	localparam int WIDTH_REG_W  = 11;
	localparam int HEIGHT_REG_W = 13;
	localparam int APB_DATA_W   = 32;
	localparam int APB_ADDR_W   = 3;

	// Line store geometry
	localparam int MAX_WIDTH = 1024;
	localparam int COL_W     = $clog2(MAX_WIDTH);
	// Row position runs up to height+1
	localparam int ROW_W     = HEIGHT_REG_W + 1;
	// Common width for comparing the width register against MAX_WIDTH
	localparam int EXT_W     = (WIDTH_REG_W > COL_W + 1) ? WIDTH_REG_W : COL_W + 1;

	// Line store word: upper row in the high half, lower row in the low half
	localparam int LS_W = 2 * PIX_W;

	// Output queue
	localparam int OFIFO_DEPTH = 4;
	localparam int OFIFO_PTR_W = $clog2(OFIFO_DEPTH);
	localparam int OFIFO_CNT_W = $clog2(OFIFO_DEPTH + 1);

	// Pixel codes
	localparam logic [PIX_W-1:0] PIX_WHITE = 8'd255;
	localparam logic [PIX_W-1:0] PIX_BLACK = 8'd0;

	// Register reset values
	localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd640;
	localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd480;

	// Register map, selected by paddr[2]
	typedef enum logic [0:0] {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} be3_reg_e;

	// Per-item control carried along the pipeline
	typedef struct packed {
		logic res_valid;
		logic use_top;
		logic use_bot;
		logic use_left;
		logic use_right;
		logic eor;
		logic eof;
	} be3_ctl_t;

	// One result transaction
	typedef struct packed {
		logic             eof;
		logic             eor;
		logic [PIX_W-1:0] pix;
	} be3_res_t;

	// Width register to last column index: 0 acts as 1, large values clamp
	function automatic logic [COL_W-1:0] eff_wm1(input logic [WIDTH_REG_W-1:0] w);
		logic [EXT_W-1:0] we;
		we = EXT_W'(w);
		if (we == '0)
			return '0;
		if (we > EXT_W'(MAX_WIDTH))
			return COL_W'(MAX_WIDTH - 1);
		return COL_W'(we - EXT_W'(1));
	endfunction

	// Height register to last row index: 0 acts as 1
	function automatic logic [HEIGHT_REG_W-1:0] eff_hm1(input logic [HEIGHT_REG_W-1:0] h);
		if (h == '0)
			return '0;
		return h - HEIGHT_REG_W'(1);
	endfunction

endpackage

@@ hdl/be3_ram.sv @@
module be3_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
	end

	// Registered read, old data on a same-address write
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

@@ hdl/be3_cell.sv @@
module be3_cell
	import be3_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             shift_en,
	input  logic [PIX_W-1:0] pix_in,
	output logic [PIX_W-1:0] pix_q,
	output logic             white_q,
	output logic             zero_q
);

	// Load the neighbor's pixel and classify it on the way in
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_q   <= PIX_BLACK;
			white_q <= 1'b0;
			zero_q  <= 1'b1;
		end else if (shift_en) begin
			pix_q   <= pix_in;
			white_q <= (pix_in == PIX_WHITE);
			zero_q  <= (pix_in == PIX_BLACK);
		end
	end

endmodule

@@ hdl/be3_ofifo.sv @@
module be3_ofifo
	import be3_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  be3_res_t               push_data,
	input  logic                   pop_ready,
	output logic                   pop_valid,
	output be3_res_t               pop_data,
	output logic [OFIFO_CNT_W-1:0] count
);

	be3_res_t               mem_q [OFIFO_DEPTH];
	logic [OFIFO_PTR_W-1:0] wr_ptr_q;
	logic [OFIFO_PTR_W-1:0] rd_ptr_q;
	logic [OFIFO_CNT_W-1:0] count_q;
	logic                   pop;

	assign pop_valid = (count_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];
	assign pop       = pop_valid & pop_ready;
	assign count     = count_q;

	// Store pushed results
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + OFIFO_PTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + OFIFO_PTR_W'(1);
			unique case ({push, pop})
				2'b10:   count_q <= count_q + OFIFO_CNT_W'(1);
				2'b01:   count_q <= count_q - OFIFO_CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ hdl/binary_erosion_3x3_stream_core.sv @@
// Path: stage 1 registers and line store read, window cells and stage 2 control, then
// the output queue; in stream order a result lags its pixel by one row plus one pixel.
// Throughput: one pixel per cycle while s_tready is high, set by the registered line store
// read and the shifting window cells; the four-entry output queue absorbs short output stalls.
// Reset (arst_n low, asynchronous): position, pipeline and queue are cleared and the
// size registers return to 640 x 480; line store contents are left as they are.
module binary_erosion_3x3_stream_core
	import be3_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	// Input stream
	input  logic                    s_tvalid,
	output logic                    s_tready,
	input  logic [7:0]              s_tdata,   // [7:0] pixel_in
	input  logic                    s_tuser,   // [0] flush
	// Output stream
	output logic                    m_tvalid,
	input  logic                    m_tready,
	output logic [7:0]              m_tdata,   // [7:0] pixel_out
	output logic                    m_tlast,   // end_of_row
	output logic                    m_tuser,   // [0] end_of_frame
	// Configuration
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [APB_ADDR_W-1:0]   paddr,
	input  logic [APB_DATA_W-1:0]   pwdata,
	output logic [APB_DATA_W-1:0]   prdata,
	output logic                    pready
);

	logic [WIDTH_REG_W-1:0]  width_q;
	logic [HEIGHT_REG_W-1:0] height_q;
	logic [COL_W-1:0]        wm1_q;
	logic [HEIGHT_REG_W-1:0] hm1_q;
	logic [COL_W-1:0]        col_q;
	logic [ROW_W-1:0]        row_q;

	logic                    acc;
	logic                    cfg_wr;
	be3_reg_e                reg_sel;
	logic [ROW_W-1:0]        hm1_ext;
	logic [ROW_W-1:0]        orow;
	logic [COL_W-1:0]        ocol;
	logic                    pos_ok;
	logic                    col_last;
	logic [COL_W-1:0]        col_nxt;
	logic [ROW_W-1:0]        row_nxt;
	be3_ctl_t                ctl;
	logic [PIX_W-1:0]        px;

	logic                    valid_s1;
	be3_ctl_t                ctl_s1;
	logic [PIX_W-1:0]        px_s1;
	logic [COL_W-1:0]        addr_s1;
	logic                    hit_s1;
	logic [LS_W-1:0]         wr_word_q;
	logic [LS_W-1:0]         rd_word;
	logic [LS_W-1:0]         ls_word;
	logic [LS_W-1:0]         ls_wdata;

	logic                    valid_s2;
	be3_ctl_t                ctl_s2;

	logic [PIX_W-1:0]        col_in  [3];
	logic [PIX_W-1:0]        win_pix [3][3];
	logic                    win_wht [3][3];
	logic                    win_zro [3][3];

	logic                    any_white;
	be3_res_t                res;
	be3_res_t                out_res;
	logic [OFIFO_CNT_W-1:0]  q_count;
	logic [OFIFO_CNT_W:0]    inflight;

	// Configuration port
	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign reg_sel = be3_reg_e'(paddr[2]);

	always_comb begin
		prdata = '0;
		unique case (reg_sel)
			REG_IMAGE_WIDTH:  prdata = APB_DATA_W'(width_q);
			REG_IMAGE_HEIGHT: prdata = APB_DATA_W'(height_q);
			default:          prdata = '0;
		endcase
	end

	// Frame position of the window centre for the incoming transaction
	assign acc     = s_tvalid & s_tready;
	assign hm1_ext = ROW_W'(hm1_q);
	assign px      = s_tuser ? PIX_BLACK : s_tdata;

	always_comb begin
		if (col_q == '0) begin
			pos_ok = (row_q >= ROW_W'(2));
			orow   = row_q - ROW_W'(2);
			ocol   = wm1_q;
		end else begin
			pos_ok = (row_q >= ROW_W'(1));
			orow   = row_q - ROW_W'(1);
			ocol   = col_q - COL_W'(1);
		end
		ctl.res_valid = pos_ok && (orow <= hm1_ext);
		ctl.use_top   = (orow != '0);
		ctl.use_bot   = (orow != hm1_ext);
		ctl.use_left  = (ocol != '0);
		ctl.use_right = (ocol != wm1_q);
		ctl.eor       = (ocol == wm1_q);
		ctl.eof       = (ocol == wm1_q) && (orow == hm1_ext);

		col_last = (col_q == wm1_q);
		col_nxt  = col_last ? '0 : col_q + COL_W'(1);
		// Row saturates at height+1 while flush items run on
		row_nxt  = (col_last && (row_q != hm1_ext + ROW_W'(2))) ? row_q + ROW_W'(1) : row_q;
	end

	// Hold size registers and advance position; a register write restarts the frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
			wm1_q    <= eff_wm1(WIDTH_RESET);
			hm1_q    <= eff_hm1(HEIGHT_RESET);
			col_q    <= '0;
			row_q    <= '0;
		end else if (cfg_wr) begin
			unique case (reg_sel)
				REG_IMAGE_WIDTH: begin
					width_q <= pwdata[WIDTH_REG_W-1:0];
					wm1_q   <= eff_wm1(pwdata[WIDTH_REG_W-1:0]);
				end
				REG_IMAGE_HEIGHT: begin
					height_q <= pwdata[HEIGHT_REG_W-1:0];
					hm1_q    <= eff_hm1(pwdata[HEIGHT_REG_W-1:0]);
				end
				default: ;
			endcase
			col_q <= '0;
			row_q <= '0;
		end else if (acc) begin
			if (ctl.res_valid && ctl.eof) begin
				col_q <= '0;
				row_q <= '0;
			end else begin
				col_q <= col_nxt;
				row_q <= row_nxt;
			end
		end
	end

	// Stage valids: stage 1 tracks the transaction while the line store is read, stage 2 follows it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= acc;
			valid_s2 <= valid_s1;
		end
	end

	// Stage payloads; flag a same-column read behind a write still in flight
	always_ff @(posedge clk) begin
		ctl_s1  <= ctl;
		px_s1   <= px;
		addr_s1 <= col_q;
		hit_s1  <= valid_s1 && (addr_s1 == col_q);
		ctl_s2  <= ctl_s1;
		if (valid_s1)
			wr_word_q <= ls_wdata;
	end

	// Line stores: one word per column, upper row high, lower row low
	assign ls_word  = hit_s1 ? wr_word_q : rd_word;
	assign ls_wdata = {ls_word[PIX_W-1:0], px_s1};

	be3_ram #(
		.WIDTH (LS_W),
		.DEPTH (MAX_WIDTH)
	) u_line_store (
		.clk   (clk),
		.we    (valid_s1),
		.waddr (addr_s1),
		.wdata (ls_wdata),
		.raddr (col_q),
		.rdata (rd_word)
	);

	// Window: three rows of cells, each shifting left by one per transaction
	assign col_in[0] = ls_word[LS_W-1:PIX_W];
	assign col_in[1] = ls_word[PIX_W-1:0];
	assign col_in[2] = px_s1;

	for (genvar y = 0; y < 3; y++) begin : g_row
		for (genvar x = 0; x < 3; x++) begin : g_col
			be3_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.shift_en (valid_s1),
				.pix_in   ((x == 2) ? col_in[y] : win_pix[y][(x == 2) ? x : x + 1]),
				.pix_q    (win_pix[y][x]),
				.white_q  (win_wht[y][x]),
				.zero_q   (win_zro[y][x])
			);
		end
	end

	// Look for a white neighbor inside the image
	always_comb begin
		any_white =
			(ctl_s2.use_top && ctl_s2.use_left  && win_wht[0][0]) ||
			(ctl_s2.use_top                     && win_wht[0][1]) ||
			(ctl_s2.use_top && ctl_s2.use_right && win_wht[0][2]) ||
			(ctl_s2.use_left                    && win_wht[1][0]) ||
			(ctl_s2.use_right                   && win_wht[1][2]) ||
			(ctl_s2.use_bot && ctl_s2.use_left  && win_wht[2][0]) ||
			(ctl_s2.use_bot                     && win_wht[2][1]) ||
			(ctl_s2.use_bot && ctl_s2.use_right && win_wht[2][2]);
		res.pix = (win_zro[1][1] && any_white) ? PIX_WHITE : win_pix[1][1];
		res.eor = ctl_s2.eor;
		res.eof = ctl_s2.eof;
	end

	// Output queue
	be3_ofifo u_ofifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (valid_s2 && ctl_s2.res_valid),
		.push_data (res),
		.pop_ready (m_tready),
		.pop_valid (m_tvalid),
		.pop_data  (out_res),
		.count     (q_count)
	);

	assign m_tdata = out_res.pix;
	assign m_tlast = out_res.eor;
	assign m_tuser = out_res.eof;

	// Accept only while every transaction in flight has a queue slot
	assign inflight = (OFIFO_CNT_W + 1)'(q_count) + (OFIFO_CNT_W + 1)'(valid_s1)
		+ (OFIFO_CNT_W + 1)'(valid_s2);
	assign s_tready = (inflight < (OFIFO_CNT_W + 1)'(OFIFO_DEPTH));

endmodule

@@ hdl/be3_checker.sv @@
module be3_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	input  logic       s_tready,
	input  logic       m_tvalid,
	input  logic       m_tready,
	input  logic [7:0] m_tdata,
	input  logic       m_tlast,
	input  logic       m_tuser
);

	// Frame end always closes a row
	a_eof_is_eor: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast)
		else $error("end of frame without end of row");

	// A rising result only follows an input transaction that passed stage 1, stage 2 and the queue
	a_result_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready, 3))
		else $error("result with no input transaction behind it");

	// Stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
			&& $stable(m_tuser))
		else $error("stalled result changed");

endmodule

bind binary_erosion_3x3_stream_core be3_checker u_be3_checker (.*);
